// File: design/four_connected_flood_fill_unit_assert.svh
// Assertion macros shared by the flood fill checker.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef FOUR_CONNECTED_FLOOD_FILL_UNIT_ASSERT_SVH
`define FOUR_CONNECTED_FLOOD_FILL_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FFU_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("flood fill unit: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define FFU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("flood fill unit: next-cycle check failed");

`endif

// File: design/ffu_pkg.sv
package ffu_pkg;

  // Fixed field widths of the item and result words.
  localparam int COORD_W   = 8;
  localparam int LEVEL_W   = 8;
  localparam int MARGIN_W  = 7;
  localparam int SIZE_W    = 17;
  // Wide enough for a coordinate plus the margin and for the largest image side.
  localparam int COORD_SUM_W = 14;

  localparam logic [MARGIN_W-1:0] MARGIN_RESET = 7'd10;

  typedef enum logic [1:0] {
    ACT_LOAD = 2'd0,
    ACT_FILL = 2'd1,
    ACT_READ = 2'd2,
    ACT_NONE = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_PUSH,
    ST_CLEAR,
    ST_SEED,
    ST_SEED_CHK,
    ST_DEQ,
    ST_NB_RD,
    ST_NB_CHK
  } state_t;

  typedef struct packed {
    logic take_item;
    logic load_pixel;
    logic read_member;
    logic push;
    logic push_zero;
    logic sweep_step;
    logic fill_start;
    logic clear_step;
    logic seed_read;
    logic seed_commit;
    logic deq;
    logic nb_first;
    logic nb_read;
    logic nb_check;
  } dp_cmd_t;

  typedef struct packed {
    logic sweep_done;
    logic clear_done;
    logic seed_ok;
    logic queue_empty;
    logic nb_last;
    logic out_free;
  } dp_status_t;

endpackage

// File: design/ffu_controller.sv
module ffu_controller (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [1:0]         in_action,
  output logic               in_stall,
  input  ffu_pkg::dp_status_t status,
  output ffu_pkg::dp_cmd_t    cmd
);
  import ffu_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_stall  = (state_r != ST_IDLE);
    case (state_r)
      ST_INIT: begin
        cmd.sweep_step = 1'b1;
        if (status.sweep_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.take_item = 1'b1;
          case (action_t'(in_action))
            ACT_LOAD, ACT_NONE: begin
              cmd.load_pixel = (action_t'(in_action) == ACT_LOAD);
              if (status.out_free) begin
                cmd.push      = 1'b1;
                cmd.push_zero = 1'b1;
              end else begin
                state_nxt = ST_PUSH;
              end
            end
            ACT_READ: begin
              cmd.read_member = 1'b1;
              state_nxt       = ST_PUSH;
            end
            ACT_FILL: begin
              cmd.fill_start = 1'b1;
              state_nxt      = ST_CLEAR;
            end
            default: begin
              state_nxt = ST_PUSH;
            end
          endcase
        end
      end
      ST_PUSH: begin
        if (status.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        if (status.clear_done) begin
          state_nxt = ST_SEED;
        end else begin
          cmd.clear_step = 1'b1;
        end
      end
      ST_SEED: begin
        cmd.seed_read = 1'b1;
        state_nxt     = ST_SEED_CHK;
      end
      ST_SEED_CHK: begin
        cmd.seed_commit = 1'b1;
        state_nxt       = status.seed_ok ? ST_DEQ : ST_PUSH;
      end
      ST_DEQ: begin
        if (status.queue_empty) begin
          state_nxt = ST_PUSH;
        end else begin
          cmd.deq      = 1'b1;
          cmd.nb_first = 1'b1;
          state_nxt    = ST_NB_RD;
        end
      end
      ST_NB_RD: begin
        cmd.nb_read = 1'b1;
        state_nxt   = ST_NB_CHK;
      end
      ST_NB_CHK: begin
        cmd.nb_check = 1'b1;
        state_nxt    = status.nb_last ? ST_DEQ : ST_NB_RD;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// File: design/ffu_datapath.sv
module ffu_datapath #(
  parameter int IMAGE_ROWS    = 256,
  parameter int IMAGE_COLUMNS = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ffu_pkg::dp_cmd_t               cmd,
  output ffu_pkg::dp_status_t            status,
  input  logic [1:0]                     in_action,
  input  logic [ffu_pkg::COORD_W-1:0]    in_row_index,
  input  logic [ffu_pkg::COORD_W-1:0]    in_column_index,
  input  logic [ffu_pkg::LEVEL_W-1:0]    in_pixel_red,
  input  logic [ffu_pkg::LEVEL_W-1:0]    in_pixel_green,
  input  logic [ffu_pkg::LEVEL_W-1:0]    in_pixel_blue,
  input  logic [ffu_pkg::MARGIN_W-1:0]   margin,
  input  logic                           out_stall,
  output logic                           out_valid,
  output logic                           out_seed_accepted,
  output logic [ffu_pkg::SIZE_W-1:0]     out_region_size,
  output logic                           out_region_member
);
  import ffu_pkg::*;

  localparam int RW        = $clog2(IMAGE_ROWS);
  localparam int CW        = $clog2(IMAGE_COLUMNS);
  localparam int AW        = RW + CW;
  localparam int MAP_DEPTH = 1 << AW;
  localparam int PIXELS    = IMAGE_ROWS * IMAGE_COLUMNS;
  localparam int CNTW      = $clog2(PIXELS + 1);
  localparam int QIW       = $clog2(PIXELS);

  // Maps and queue.
  logic          black_mem [MAP_DEPTH];
  logic          vis_mem   [MAP_DEPTH];
  logic [AW-1:0] queue_mem [PIXELS];
  logic          black_q;
  logic          vis_q;
  logic [AW-1:0] q_rd_q;

  // Latched item.
  action_t                act_r;
  logic [COORD_W-1:0]     row_r;
  logic [COORD_W-1:0]     col_r;
  logic                   inimg_r;
  logic                   margin_ok_r;
  logic                   acc_r;

  // Fill control counters.
  logic [CNTW-1:0] head_r;
  logic [CNTW-1:0] tail_r;
  logic [CNTW-1:0] count_r;
  logic [CNTW-1:0] clr_idx_r;
  logic            clr_pend_r;
  logic [AW-1:0]   sweep_r;
  logic [1:0]      nbr_r;
  logic            nb_valid_r;
  logic [AW-1:0]   nb_addr_r;

  logic                   out_valid_r;
  logic                   out_seed_accepted_r;
  logic [SIZE_W-1:0]      out_region_size_r;
  logic                   out_region_member_r;

  logic [COORD_SUM_W-1:0] rs;
  logic [COORD_SUM_W-1:0] cs;
  logic [COORD_SUM_W-1:0] ms;
  logic                   in_inimg;
  logic                   in_margin_ok;
  logic [AW-1:0]          in_addr;
  logic [AW-1:0]          seed_addr;
  logic [RW-1:0]          pr;
  logic [CW-1:0]          pc;
  logic                   nb_ok;
  logic [AW-1:0]          nb_addr;
  logic                   nb_hit;
  logic                   seed_ok;
  logic                   clr_more;

  logic          vis_we;
  logic [AW-1:0] vis_waddr;
  logic          vis_wdata;
  logic          vis_re;
  logic [AW-1:0] vis_raddr;
  logic          black_we;
  logic          black_re;
  logic [AW-1:0] black_raddr;
  logic          q_we;
  logic [QIW-1:0] q_waddr;
  logic [AW-1:0] q_wdata;
  logic          q_re;
  logic [QIW-1:0] q_raddr;

  // Item checks: inside the image, and far enough from every edge.
  always_comb begin
    rs = COORD_SUM_W'(in_row_index);
    cs = COORD_SUM_W'(in_column_index);
    ms = COORD_SUM_W'(margin);
    in_inimg = (rs < COORD_SUM_W'(IMAGE_ROWS)) && (cs < COORD_SUM_W'(IMAGE_COLUMNS));
    in_margin_ok = !((rs < ms) || (cs < ms) ||
                     ((rs + ms) >= COORD_SUM_W'(IMAGE_ROWS)) ||
                     ((cs + ms) >= COORD_SUM_W'(IMAGE_COLUMNS)));
    in_addr   = {RW'(in_row_index), CW'(in_column_index)};
    seed_addr = {RW'(row_r), CW'(col_r)};
  end

  // Neighbor of the dequeued pixel selected by nbr_r.
  assign pr = q_rd_q[AW-1:CW];
  assign pc = q_rd_q[CW-1:0];

  always_comb begin
    case (nbr_r)
      2'd0: begin
        nb_ok   = (pr != '0);
        nb_addr = {pr - 1'b1, pc};
      end
      2'd1: begin
        nb_ok   = (pr != RW'(IMAGE_ROWS - 1));
        nb_addr = {pr + 1'b1, pc};
      end
      2'd2: begin
        nb_ok   = (pc != '0);
        nb_addr = {pr, pc - 1'b1};
      end
      default: begin
        nb_ok   = (pc != CW'(IMAGE_COLUMNS - 1));
        nb_addr = {pr, pc + 1'b1};
      end
    endcase
  end

  assign nb_hit   = nb_valid_r && black_q && !vis_q;
  assign seed_ok  = inimg_r && margin_ok_r && black_q;
  assign clr_more = (clr_idx_r != count_r);

  // Memory port selection.
  always_comb begin
    vis_we    = 1'b0;
    vis_waddr = sweep_r;
    vis_wdata = 1'b0;
    if (cmd.sweep_step) begin
      vis_we = 1'b1;
    end else if (clr_pend_r) begin
      vis_we    = 1'b1;
      vis_waddr = q_rd_q;
    end else if (cmd.seed_commit && seed_ok) begin
      vis_we    = 1'b1;
      vis_waddr = seed_addr;
      vis_wdata = 1'b1;
    end else if (cmd.nb_check && nb_hit) begin
      vis_we    = 1'b1;
      vis_waddr = nb_addr_r;
      vis_wdata = 1'b1;
    end
    vis_re    = cmd.read_member || cmd.nb_read;
    vis_raddr = cmd.read_member ? in_addr : nb_addr;

    black_we    = cmd.load_pixel && in_inimg;
    black_re    = cmd.seed_read || cmd.nb_read;
    black_raddr = cmd.seed_read ? seed_addr : nb_addr;

    q_we    = 1'b0;
    q_waddr = '0;
    q_wdata = seed_addr;
    if (cmd.seed_commit && seed_ok) begin
      q_we = 1'b1;
    end else if (cmd.nb_check && nb_hit) begin
      q_we    = 1'b1;
      q_waddr = tail_r[QIW-1:0];
      q_wdata = nb_addr_r;
    end
    q_re    = (cmd.clear_step && clr_more) || cmd.deq;
    q_raddr = cmd.deq ? head_r[QIW-1:0] : clr_idx_r[QIW-1:0];
  end

  always_ff @(posedge clk) begin
    if (vis_we) begin
      vis_mem[vis_waddr] <= vis_wdata;
    end
    if (vis_re) begin
      vis_q <= vis_mem[vis_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (black_we) begin
      black_mem[in_addr] <= ~|{in_pixel_red, in_pixel_green, in_pixel_blue};
    end
    if (black_re) begin
      black_q <= black_mem[black_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      queue_mem[q_waddr] <= q_wdata;
    end
    if (q_re) begin
      q_rd_q <= queue_mem[q_raddr];
    end
  end

  // Control counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      clr_idx_r   <= '0;
      clr_pend_r  <= 1'b0;
      sweep_r     <= '0;
      nbr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.sweep_step) begin
        sweep_r <= sweep_r + 1'b1;
      end
      if (cmd.fill_start) begin
        clr_idx_r  <= '0;
        clr_pend_r <= 1'b0;
      end else if (cmd.clear_step) begin
        clr_pend_r <= clr_more;
        if (clr_more) begin
          clr_idx_r <= clr_idx_r + 1'b1;
        end
      end
      if (cmd.seed_commit) begin
        head_r  <= '0;
        count_r <= '0;
        tail_r  <= seed_ok ? CNTW'(1) : '0;
      end
      if (cmd.deq) begin
        head_r  <= head_r + 1'b1;
        count_r <= count_r + 1'b1;
      end
      if (cmd.nb_check && nb_hit) begin
        tail_r <= tail_r + 1'b1;
      end
      if (cmd.nb_first) begin
        nbr_r <= '0;
      end else if (cmd.nb_check) begin
        nbr_r <= nbr_r + 1'b1;
      end
      if (cmd.push) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      act_r       <= action_t'(in_action);
      row_r       <= in_row_index;
      col_r       <= in_column_index;
      inimg_r     <= in_inimg;
      margin_ok_r <= in_margin_ok;
    end
    if (cmd.seed_commit) begin
      acc_r <= seed_ok;
    end
    if (cmd.nb_read) begin
      nb_valid_r <= nb_ok;
      nb_addr_r  <= nb_addr;
    end
    if (cmd.push) begin
      out_seed_accepted_r <= 1'b0;
      out_region_size_r   <= '0;
      out_region_member_r <= 1'b0;
      if (!cmd.push_zero) begin
        case (act_r)
          ACT_FILL: begin
            out_seed_accepted_r <= acc_r;
            out_region_size_r   <= SIZE_W'(count_r);
          end
          ACT_READ: begin
            out_region_member_r <= vis_q && inimg_r;
          end
          default: begin
            out_region_size_r <= '0;
          end
        endcase
      end
    end
  end

  assign status.sweep_done  = &sweep_r;
  assign status.clear_done  = !clr_more && !clr_pend_r;
  assign status.seed_ok     = seed_ok;
  assign status.queue_empty = (head_r == tail_r);
  assign status.nb_last     = (nbr_r == 2'd3);
  assign status.out_free    = !out_valid_r || !out_stall;

  assign out_valid         = out_valid_r;
  assign out_seed_accepted = out_seed_accepted_r;
  assign out_region_size   = out_region_size_r;
  assign out_region_member = out_region_member_r;

endmodule

// File: design/four_connected_flood_fill_unit.sv
// Four-connected flood fill unit. Load words write one pixel of an
// IMAGE_ROWS x IMAGE_COLUMNS image as black (all levels zero) or not black,
// fill words start a breadth-first 4-connected fill from a seed that must be
// black and at least border_margin pixels inside every edge, and read words
// ask whether a pixel belongs to the region of the last fill; every word gives
// exactly one result word. After reset the unit sweeps the whole visited map
// clear with the input stalled; the margin register can be written during
// that time. A load, or an unused action, is finished in the idle state when
// the output register is free; a read waits for the registered visited-map
// read. A fill first walks the queue entries of the previous region to clear
// their visited bits and then checks the seed; an accepted seed starts the
// breadth-first walk, in which each dequeued pixel costs one queue read and
// then a read and a check for each of its four neighbors, because the black
// and visited maps have one registered read port each and a neighbor's check
// must see the marks of the one before it. The result word is held in an
// output register, so the next word is taken while it waits.

module four_connected_flood_fill_unit #(
  parameter int IMAGE_ROWS    = 256,
  parameter int IMAGE_COLUMNS = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input words.
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_action,
  input  logic [ffu_pkg::COORD_W-1:0]    in_row_index,
  input  logic [ffu_pkg::COORD_W-1:0]    in_column_index,
  input  logic [ffu_pkg::LEVEL_W-1:0]    in_pixel_red,
  input  logic [ffu_pkg::LEVEL_W-1:0]    in_pixel_green,
  input  logic [ffu_pkg::LEVEL_W-1:0]    in_pixel_blue,
  // Result words.
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_seed_accepted,
  output logic [ffu_pkg::SIZE_W-1:0]     out_region_size,
  output logic                           out_region_member,
  // Border margin register write.
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ffu_pkg::MARGIN_W-1:0]   cfg_data
);
  import ffu_pkg::*;

  logic [MARGIN_W-1:0] margin_r;
  dp_cmd_t             cmd;
  dp_status_t          status;

  // Always ready, not enforced by the block: the margin register must be written
  // only while the unit is idle, so a fill in flight never sees it change.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      margin_r <= MARGIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      margin_r <= cfg_data;
    end
  end

  // The controller sequences the reset sweep, the clearing pass, the seed
  // check and the breadth-first walk; the datapath holds the maps, the queue,
  // the counters and the output register.
  ffu_controller u_controller (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_stall  (in_stall),
    .status    (status),
    .cmd       (cmd)
  );

  ffu_datapath #(
    .IMAGE_ROWS    (IMAGE_ROWS),
    .IMAGE_COLUMNS (IMAGE_COLUMNS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_action         (in_action),
    .in_row_index      (in_row_index),
    .in_column_index   (in_column_index),
    .in_pixel_red      (in_pixel_red),
    .in_pixel_green    (in_pixel_green),
    .in_pixel_blue     (in_pixel_blue),
    .margin            (margin_r),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_seed_accepted (out_seed_accepted),
    .out_region_size   (out_region_size),
    .out_region_member (out_region_member)
  );

endmodule

// File: design/ffu_checker.sv
`include "four_connected_flood_fill_unit_assert.svh"

module ffu_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic [1:0]                 in_action,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic                       out_seed_accepted,
  input logic [ffu_pkg::SIZE_W-1:0] out_region_size,
  input logic                       out_region_member
);
  import ffu_pkg::*;

  // A stalled result word stays and holds its fields.
  `FFU_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_region_size) && $stable(out_seed_accepted) && $stable(out_region_member))

  // Only an accepted fill reports a region size.
  `FFU_ASSERT_SAME(a_size_needs_seed, out_valid && !out_seed_accepted, out_region_size == '0)

  // A membership answer never carries fill fields.
  `FFU_ASSERT_SAME(a_member_alone, out_valid && out_region_member, !out_seed_accepted && (out_region_size == '0))

  // A fill always holds the input for at least its clearing and seed check.
  `FFU_ASSERT_NEXT(a_fill_stalls, in_valid && !in_stall && (in_action == ACT_FILL), in_stall)

endmodule

bind four_connected_flood_fill_unit ffu_checker u_checker (.*);
